// ----- hdl/mchd_pkg.sv -----
// Shared types, constants and codes for the multi-click and hold detector.
package mchd_pkg;

   localparam int TIME_BITS = 32;

   localparam int CSR_COUNT = 3;
   localparam int CSR_INDEX_BITS = $clog2(CSR_COUNT);
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_DATA_BITS-1:0] RELEASE_MS_RESET = 16'd200;
   localparam logic [CSR_DATA_BITS-1:0] HOLD_MIN_MS_RESET = 16'd1000;
   localparam logic [CSR_DATA_BITS-1:0] DEBOUNCE_MS_RESET = 16'd50;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RELEASE_MS  = 2'd0,
      CSR_HOLD_MIN_MS = 2'd1,
      CSR_DEBOUNCE_MS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_CLICK_END = 2'd0,
      EV_HOLD_END  = 2'd1,
      EV_HOLD_PROG = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [31:0] time_ms;
      logic        edge_seen;
      logic        pin_high;
   } req_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [7:0]     click_count;
      logic [31:0]    hold_ms;
      logic           last_of_run;
   } rsp_type;

   typedef struct packed {
      logic           has_end;
      event_kind_type end_kind;
      logic [7:0]     end_count;
      logic           has_prog;
      logic [7:0]     prog_count;
      logic [31:0]    duration;
   } plan_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] release_ms;
      logic [CSR_DATA_BITS-1:0] hold_min_ms;
      logic [CSR_DATA_BITS-1:0] debounce_ms;
   } csr_type;

endpackage

// ----- hdl/mchd_front.sv -----
// Front end: configuration registers, poll acceptance and click/hold state update.
module mchd_front import mchd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_payload,
   output logic                      plan_valid,
   input  logic                      plan_ready,
   output plan_type                  plan
);

   csr_type csr_ff;

   logic                 press_latch_ff, press_latch_in;
   logic [7:0]           click_total_ff, click_total_in;
   logic [TIME_BITS-1:0] hold_start_ff, hold_start_in;
   logic [TIME_BITS-1:0] last_press_ff, last_press_in;
   logic                 pressed_ff, pressed_in;

   logic                 accept;
   logic                 detected;
   logic                 in_hold;
   logic                 series_end;
   logic [TIME_BITS-1:0] now;
   logic [TIME_BITS-1:0] since_press;
   logic [TIME_BITS-1:0] duration;
   logic [7:0]           count_mid;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.release_ms <= RELEASE_MS_RESET;
         csr_ff.hold_min_ms <= HOLD_MIN_MS_RESET;
         csr_ff.debounce_ms <= DEBOUNCE_MS_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_RELEASE_MS:  csr_ff.release_ms <= csr_wdata;
            CSR_HOLD_MIN_MS: csr_ff.hold_min_ms <= csr_wdata;
            CSR_DEBOUNCE_MS: csr_ff.debounce_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = !plan_ready;
   assign accept = req_valid && plan_ready;

   always_comb begin
      now = TIME_BITS'(req_payload.time_ms);
      press_latch_in = (press_latch_ff || req_payload.edge_seen) && !req_payload.pin_high;
      detected = press_latch_in;
      since_press = now - last_press_ff;
      duration = now - hold_start_ff;
      in_hold = pressed_ff && (duration > TIME_BITS'(csr_ff.hold_min_ms));
      series_end = (since_press > TIME_BITS'(csr_ff.release_ms)) ||
                   (in_hold && (since_press > TIME_BITS'(csr_ff.release_ms >> 1)));

      count_mid = series_end ? 8'd0 : click_total_ff;
      click_total_in = count_mid;
      pressed_in = series_end ? 1'b0 : pressed_ff;
      hold_start_in = series_end ? now : hold_start_ff;
      last_press_in = last_press_ff;
      if (detected) begin
         if ((since_press > TIME_BITS'(csr_ff.debounce_ms)) && !in_hold) begin
            click_total_in = count_mid + 8'd1;
            hold_start_in = now;
         end
         last_press_in = now;
         pressed_in = 1'b1;
      end

      plan.has_end = series_end;
      plan.end_kind = in_hold ? EV_HOLD_END : EV_CLICK_END;
      plan.end_count = click_total_ff;
      plan.has_prog = in_hold;
      plan.prog_count = click_total_in;
      plan.duration = 32'(duration);
      plan_valid = accept && (series_end || in_hold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_latch_ff <= 1'b0;
         click_total_ff <= 8'd0;
         hold_start_ff <= '0;
         last_press_ff <= '0;
         pressed_ff <= 1'b0;
      end else if (accept) begin
         press_latch_ff <= press_latch_in;
         click_total_ff <= click_total_in;
         hold_start_ff <= hold_start_in;
         last_press_ff <= last_press_in;
         pressed_ff <= pressed_in;
      end
   end

endmodule

// ----- hdl/mchd_queue.sv -----
// Short queue of result plans between the front end and the result sequencer.
module mchd_queue import mchd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  plan_type push_data,
   output logic     ready,
   output logic     head_valid,
   input  logic     pop,
   output plan_type head_data
);

   plan_type entry_ff [QUEUE_DEPTH];

   logic [QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign ready = count_ff != (QPTR_BITS + 1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data = entry_ff[rptr_ff];
   assign do_push = push && ready;
   assign do_pop = pop && head_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/mchd_back.sv -----
// Result sequencer: turns each queued plan into one or two result beats.
module mchd_back import mchd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  plan_type head_data,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;
   logic    phase_ff, phase_in;
   logic    out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      phase_in = phase_ff;
      pop = 1'b0;
      if (out_free) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (head_data.has_end && !phase_ff) begin
               rsp_payload_in.event_kind = head_data.end_kind;
               rsp_payload_in.click_count = head_data.end_count;
               rsp_payload_in.hold_ms = 32'd0;
               rsp_payload_in.last_of_run = !head_data.has_prog;
               phase_in = head_data.has_prog;
               pop = !head_data.has_prog;
            end else begin
               rsp_payload_in.event_kind = EV_HOLD_PROG;
               rsp_payload_in.click_count = head_data.prog_count;
               rsp_payload_in.hold_ms = head_data.duration;
               rsp_payload_in.last_of_run = 1'b1;
               phase_in = 1'b0;
               pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ----- hdl/multi_click_hold_detector.sv -----
// Multi-click and long-hold button detector, top level.
//
// The req channel takes one poll per beat: timestamp, press-edge flag and pin level.
// The rsp channel returns zero, one or two result beats per poll, in poll order.
// The last beat of each poll has last_of_run set; polls that cause no result
// produce no beat.
// The csr port writes release, hold and debounce times by index; the user must
// write only while idle, as the block itself does not enforce it. A poll is accepted
// whenever the result queue has room; its plan is written into a queue entry and
// its first result beat into the output register once the output is free. The result
// sequencer sends one beat per cycle unless stalled; a two-result poll holds it for
// both beats. When the receiver stalls, the output register holds its beat and the
// queue keeps taking polls until its four entries are full; then req_stall rises.
// Synchronous reset clears the press state, queue and output valid and loads
// the reset values of the three time registers.
module multi_click_hold_detector import mchd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_payload
);

   logic     plan_valid;
   logic     plan_ready;
   plan_type plan;
   logic     head_valid;
   plan_type head_data;
   logic     pop;

   mchd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .plan_valid  (plan_valid),
      .plan_ready  (plan_ready),
      .plan        (plan)
   );

   mchd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (plan_valid),
      .push_data  (plan),
      .ready      (plan_ready),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  (head_data)
   );

   mchd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- hdl/mchd_checker.sv -----
// Port-level checker for the detector and its bind to the top level.
module mchd_checker import mchd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_stall_holds_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp beat changed");

   a_end_has_no_duration: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_kind != EV_HOLD_PROG) |-> rsp_payload.hold_ms == 32'd0)
      else $error("series end beat carries a hold duration");

   a_hold_end_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_kind == EV_HOLD_END) |-> !rsp_payload.last_of_run)
      else $error("hold end beat not followed by progress beat");

   a_progress_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_kind == EV_HOLD_PROG) |-> rsp_payload.last_of_run)
      else $error("progress beat not last of its poll");

endmodule

bind multi_click_hold_detector mchd_checker u_checker (.*);
